[rtl/core/dtfp_pkg.sv]
// Shared types, constants and helper function of the decimal text parser.
package dtfp_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int MAX_FRAC_DIGITS = 9;
  localparam int INT_BITS        = 31;

  localparam int CH_W       = 8;
  localparam int VALUE_W    = 48;
  localparam int FRAC_ACC_W = 30;
  localparam int CNT_W      = 4;
  localparam int MAG_W      = INT_BITS + FRAC_BITS;
  localparam int SUM_W      = (MAG_W > VALUE_W) ? MAG_W : VALUE_W;
  localparam int STEP_W     = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;

  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [INT_BITS-1:0] INT_MAX = '1;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;

  typedef enum logic [1:0] {
    RSN_NUL   = 2'd0,
    RSN_DOT   = 2'd1,
    RSN_OTHER = 2'd2
  } reason_e;

  typedef struct packed {
    logic                  negative;
    logic [INT_BITS-1:0]   int_acc;
    logic [FRAC_ACC_W-1:0] frac_acc;
    logic [CNT_W-1:0]      frac_count;
    logic                  clamped;
    reason_e               reason;
  } number_t;

  typedef struct packed {
    logic    valid;
    number_t num;
  } q_word_t;

  typedef struct packed {
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [CNT_W-1:0] n);
    logic [FRAC_ACC_W-1:0] p;
    unique case (n)
      4'd1:    p = FRAC_ACC_W'(10);
      4'd2:    p = FRAC_ACC_W'(100);
      4'd3:    p = FRAC_ACC_W'(1000);
      4'd4:    p = FRAC_ACC_W'(10000);
      4'd5:    p = FRAC_ACC_W'(100000);
      4'd6:    p = FRAC_ACC_W'(1000000);
      4'd7:    p = FRAC_ACC_W'(10000000);
      4'd8:    p = FRAC_ACC_W'(100000000);
      4'd9:    p = FRAC_ACC_W'(1000000000);
      default: p = FRAC_ACC_W'(1);
    endcase
    return p;
  endfunction

endpackage

[rtl/core/dtfp_front.sv]
// Character front end: sign, integer and fraction accumulation, stop detection.
module dtfp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        ch_valid_i,
  input  logic [dtfp_pkg::CH_W-1:0]   ch_i,
  input  dtfp_pkg::q_stat_t           q_stat_i,
  output logic                        ch_ready_o,
  output dtfp_pkg::q_word_t           push_o
);

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_INT   = 4'b0010,
    PH_FRAC  = 4'b0100,
    PH_SKIP  = 4'b1000
  } phase_e;

  localparam int IW = dtfp_pkg::INT_BITS;
  localparam int FW = dtfp_pkg::FRAC_ACC_W;
  localparam int CW = dtfp_pkg::CNT_W;

  phase_e          phase_q, phase_d;
  logic            neg_q, neg_d;
  logic [IW-1:0]   int_q, int_d;
  logic [FW-1:0]   frac_q, frac_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            clamp_q, clamp_d;

  logic            accept;
  logic            is_digit;
  logic            in_frac;
  logic [3:0]      digit;
  logic [IW+3:0]   int_prod;
  logic [FW+3:0]   frac_prod;

  assign ch_ready_o = !q_stat_i.full;
  assign accept     = ch_valid_i && !q_stat_i.full;
  assign is_digit   = (ch_i >= dtfp_pkg::CH_ZERO) && (ch_i <= dtfp_pkg::CH_NINE);
  assign digit      = 4'(ch_i - dtfp_pkg::CH_ZERO);
  assign in_frac    = (phase_q == PH_FRAC);

  assign int_prod  = (IW+4)'({int_q, 3'b000}) + (IW+4)'({int_q, 1'b0}) + (IW+4)'(digit);
  assign frac_prod = (FW+4)'({frac_q, 3'b000}) + (FW+4)'({frac_q, 1'b0}) + (FW+4)'(digit);

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    int_d   = int_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    clamp_d = clamp_q;
    push_o.valid          = 1'b0;
    push_o.num.negative   = neg_q;
    push_o.num.int_acc    = int_q;
    push_o.num.frac_acc   = frac_q;
    push_o.num.frac_count = cnt_q;
    push_o.num.clamped    = clamp_q;
    push_o.num.reason     = dtfp_pkg::RSN_NUL;
    if (accept) begin
      priority if (phase_q == PH_SKIP) begin
        if (ch_i == dtfp_pkg::CH_NUL) begin
          phase_d = PH_START;
        end
      end else if ((phase_q == PH_START) && (ch_i == dtfp_pkg::CH_MINUS)) begin
        neg_d   = 1'b1;
        phase_d = PH_INT;
      end else if ((phase_q == PH_START) && (ch_i == dtfp_pkg::CH_PLUS)) begin
        phase_d = PH_INT;
      end else begin
        phase_d = in_frac ? PH_FRAC : PH_INT;
        priority if (is_digit) begin
          if (in_frac) begin
            if (cnt_q < CW'(dtfp_pkg::MAX_FRAC_DIGITS)) begin
              frac_d = frac_prod[FW-1:0];
              cnt_d  = cnt_q + 1'b1;
            end
          end else if (int_prod > (IW+4)'(dtfp_pkg::INT_MAX)) begin
            int_d   = dtfp_pkg::INT_MAX;
            clamp_d = 1'b1;
          end else begin
            int_d = int_prod[IW-1:0];
          end
        end else if (ch_i == dtfp_pkg::CH_NUL) begin
          push_o.valid      = 1'b1;
          push_o.num.reason = dtfp_pkg::RSN_NUL;
          phase_d           = PH_START;
        end else if ((ch_i == dtfp_pkg::CH_DOT) && !in_frac) begin
          phase_d = PH_FRAC;
        end else if (ch_i == dtfp_pkg::CH_DOT) begin
          push_o.valid      = 1'b1;
          push_o.num.reason = dtfp_pkg::RSN_DOT;
          phase_d           = PH_SKIP;
        end else begin
          push_o.valid      = 1'b1;
          push_o.num.reason = dtfp_pkg::RSN_OTHER;
          phase_d           = PH_SKIP;
        end
        if (push_o.valid) begin
          neg_d   = 1'b0;
          int_d   = '0;
          frac_d  = '0;
          cnt_d   = '0;
          clamp_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      neg_q   <= 1'b0;
      int_q   <= '0;
      frac_q  <= '0;
      cnt_q   <= '0;
      clamp_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      int_q   <= int_d;
      frac_q  <= frac_d;
      cnt_q   <= cnt_d;
      clamp_q <= clamp_d;
    end
  end

endmodule

[rtl/core/dtfp_queue.sv]
// Small first-in first-out queue of parsed numbers between front and back.
module dtfp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtfp_pkg::q_word_t push_i,
  input  logic              pop_i,
  output dtfp_pkg::q_word_t head_o,
  output dtfp_pkg::q_stat_t stat_o
);

  localparam int PW = dtfp_pkg::QPTR_W;
  localparam int CW = dtfp_pkg::QCNT_W;

  dtfp_pkg::number_t mem_q [dtfp_pkg::Q_DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign stat_o.full  = (count_q == CW'(dtfp_pkg::Q_DEPTH));
  assign stat_o.count = count_q;
  assign head_o.valid = (count_q != '0);
  assign head_o.num   = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !stat_o.full;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(dtfp_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(dtfp_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.num;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[rtl/core/dtfp_back.sv]
// Back end: bit-serial fraction division, signed assembly and output register.
module dtfp_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dtfp_pkg::q_word_t              head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dtfp_pkg::VALUE_W-1:0]   value_o,
  output logic                           saturated_o,
  output dtfp_pkg::reason_e              reason_o
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_DONE = 3'b100
  } back_state_e;

  localparam int IW = dtfp_pkg::INT_BITS;
  localparam int FW = dtfp_pkg::FRAC_ACC_W;
  localparam int QW = dtfp_pkg::FRAC_BITS;
  localparam int SW = dtfp_pkg::STEP_W;

  back_state_e         state_q, state_d;
  logic [SW-1:0]       step_q, step_d;
  logic                out_valid_q, out_valid_d;

  logic                neg_q, neg_d;
  logic [IW-1:0]       int_q, int_d;
  logic                clamp_q, clamp_d;
  dtfp_pkg::reason_e   rsn_q, rsn_d;
  logic [FW-1:0]       rem_q, rem_d;
  logic [FW-1:0]       div_q, div_d;
  logic [QW-1:0]       quo_q, quo_d;

  logic [dtfp_pkg::VALUE_W-1:0] value_q, value_d;
  logic                         sat_q, sat_d;
  dtfp_pkg::reason_e            out_rsn_q, out_rsn_d;

  logic [FW:0]                  rem_shift;
  logic                         fits;
  logic [dtfp_pkg::SUM_W-1:0]   mag;
  logic [dtfp_pkg::SUM_W-1:0]   signed_mag;
  logic                         load_out;

  assign rem_shift  = {rem_q, 1'b0};
  assign fits       = (rem_shift >= {1'b0, div_q});
  assign mag        = dtfp_pkg::SUM_W'({int_q, quo_q});
  assign signed_mag = neg_q ? (~mag + 1'b1) : mag;
  assign load_out   = (state_q == B_DONE) && (!out_valid_q || out_ready_i);

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign saturated_o = sat_q;
  assign reason_o    = out_rsn_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    neg_d       = neg_q;
    int_d       = int_q;
    clamp_d     = clamp_q;
    rsn_d       = rsn_q;
    rem_d       = rem_q;
    div_d       = div_q;
    quo_d       = quo_q;
    value_d     = value_q;
    sat_d       = sat_q;
    out_rsn_d   = out_rsn_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          neg_d   = head_i.num.negative;
          int_d   = head_i.num.int_acc;
          clamp_d = head_i.num.clamped;
          rsn_d   = head_i.num.reason;
          rem_d   = head_i.num.frac_acc;
          div_d   = dtfp_pkg::pow10(head_i.num.frac_count);
          quo_d   = '0;
          step_d  = SW'(QW - 1);
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        rem_d = fits ? FW'(rem_shift - {1'b0, div_q}) : rem_shift[FW-1:0];
        quo_d = {quo_q[QW-2:0], fits};
        if (step_q == '0) begin
          state_d = B_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      B_DONE: begin
        if (load_out) begin
          value_d     = signed_mag[dtfp_pkg::VALUE_W-1:0];
          sat_d       = clamp_q;
          out_rsn_d   = rsn_q;
          out_valid_d = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    step_q    <= step_d;
    neg_q     <= neg_d;
    int_q     <= int_d;
    clamp_q   <= clamp_d;
    rsn_q     <= rsn_d;
    rem_q     <= rem_d;
    div_q     <= div_d;
    quo_q     <= quo_d;
    value_q   <= value_d;
    sat_q     <= sat_d;
    out_rsn_q <= out_rsn_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/core/decimal_text_to_fixed_parser_top.sv]
// Top level of the decimal text to signed fixed-point parser.
//
//   Channel   Dir  Signals                 Word contents
//   s_axis    in   tvalid, tready, tdata   one ASCII character
//   m_axis    out  tvalid, tready, tdata,  parsed value, saturation flag and
//                  tuser                   stop reason
//
// The front end takes one character per cycle and finishes a number in the
// cycle of its stop character. The back end works on one number at a time
// with its one-bit-per-cycle fraction divider. A four-word queue sits
// between the two, and the input stalls only while that queue is full.
// Reset is asynchronous and active low and leaves the parser at string start.
module decimal_text_to_fixed_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [47:0] value
  output logic [2:0]  m_axis_tuser_o    // [0] saturated, [2:1] stop_reason
);

  dtfp_pkg::q_word_t push;
  dtfp_pkg::q_word_t head;
  dtfp_pkg::q_stat_t q_stat;
  logic              pop;
  logic              sat;
  dtfp_pkg::reason_e reason;

  dtfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ch_valid_i (s_axis_tvalid_i),
    .ch_i       (s_axis_tdata_i),
    .q_stat_i   (q_stat),
    .ch_ready_o (s_axis_tready_o),
    .push_o     (push)
  );

  dtfp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  dtfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .value_o     (m_axis_tdata_o),
    .saturated_o (sat),
    .reason_o    (reason)
  );

  assign m_axis_tuser_o = {reason, sat};

`ifndef NO_ASSERTIONS
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !q_stat.full)
    else $error("Number pushed into a full queue.");

  a_pop_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("Back end popped an empty queue.");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.valid && !pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
    else $error("Queue count did not follow a lone push.");
`endif

endmodule
